// ===== design/dbid_pkg.sv =====
// Shared types and constants for the delta bitstream image decoder.
// Used by the byte queue, the bit decoder, the result queue and the top level.
`default_nettype none

package dbid_pkg;

  localparam int DIM_BITS   = 16;
  localparam int PIX_W      = 16;
  localparam int CFG_DATA_W = 16;

  // Decode phases
  localparam logic [1:0] PH_SEED  = 2'd0;
  localparam logic [1:0] PH_CODE  = 2'd1;
  localparam logic [1:0] PH_WBIT  = 2'd2;
  localparam logic [1:0] PH_FIELD = 2'd3;

  // Group codes and field widths
  localparam logic [7:0] CODE_REPEAT = 8'd0;
  localparam logic [7:0] CODE_WIDE   = 8'd7;
  localparam logic [3:0] SEED_BITS   = 4'd8;
  localparam logic [3:0] CODE_BITS   = 4'd3;
  localparam logic [3:0] WBIT_BITS   = 4'd1;
  localparam logic [3:0] RAW_WIDTH   = 4'd8;
  localparam logic [2:0] REP_GROUP   = 3'd4;
  localparam logic [1:0] LAST_SLOT   = 2'd3;

  // Colour planes
  localparam logic [1:0] PLANE_RED  = 2'd0;
  localparam logic [1:0] PLANE_BLUE = 2'd2;

  // Register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // Queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_image;
  } byte_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [1:0]       color_plane;
    logic [7:0]       sample_value;
    logic             last_of_item;
    logic             end_of_image;
  } result_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]          pend_bits;
    logic [3:0]          pend_count;
    logic [1:0]          phase;
    logic [3:0]          field_width;
    logic [1:0]          slot;
    logic [7:0]          cur;
    logic [1:0]          plane;
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] row;
    logic                discard;
    logic                finished;
  } dec_state_t;

  localparam dec_state_t DEC_RESET = '{
    pend_bits:   8'd0,
    pend_count:  4'd0,
    phase:       PH_SEED,
    field_width: 4'd0,
    slot:        2'd0,
    cur:         8'd0,
    plane:       PLANE_BLUE,
    col:         '0,
    row:         '0,
    discard:     1'b0,
    finished:    1'b0
  };

endpackage

`default_nettype wire

// ===== design/dbid_inq.sv =====
// Front byte queue: accepts stream words and holds them for the bit decoder.
// Depends on dbid_pkg for the word type and queue geometry.
`default_nettype none

module dbid_inq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dbid_pkg::byte_word_t wr_word,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output dbid_pkg::byte_word_t rd_word
);
  import dbid_pkg::*;

  byte_word_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_word;
  end

endmodule

`default_nettype wire

// ===== design/dbid_dec.sv =====
// Back end: walks queued bytes one bit a cycle unless stalled or repeating, decodes seeds,
// codes and delta fields, and hands samples to the result queue. Depends on dbid_pkg.
`default_nettype none

module dbid_dec (
  input  logic                 clk,
  input  logic                 rst,
  input  dbid_pkg::cfg_t       cfg,
  input  logic                 in_empty,
  input  dbid_pkg::byte_word_t in_word,
  output logic                 in_pop,
  input  logic                 out_full,
  output logic                 out_push,
  output dbid_pkg::result_t    out_word
);
  import dbid_pkg::*;

  localparam logic [2:0] BIT_FIRST = 3'd7;
  localparam logic [2:0] BIT_LAST  = 3'd0;

  dec_state_t st, n, eff, src;
  logic [2:0] bidx, bidx_next;
  logic       rep_on, rep_on_next;
  logic [2:0] rep_cnt, rep_cnt_next;
  logic       rep_last, rep_last_next;
  result_t    hold, em;
  logic       hold_valid, hold_done;

  logic                in_pop_req, byte_end, emit_now, stall;
  logic [7:0]          emit_val;
  logic [DIM_BITS-1:0] col_inc, col_after, row_after;
  logic                wrap, full_src, full_after;
  logic [PIX_W-1:0]    x16;

  function automatic logic plane_full(input cfg_t c, input logic [DIM_BITS-1:0] r);
    return (c.width == '0) || (c.height == '0) || (r >= c.height);
  endfunction

  function automatic dec_state_t finish_plane(input dec_state_t s);
    dec_state_t r;
    r = s;
    if (s.plane == PLANE_RED) begin
      r.finished = 1'b1;
    end else begin
      r.plane   = s.plane - 2'd1;
      r.phase   = PH_SEED;
      r.col     = '0;
      r.row     = '0;
      r.slot    = 2'd0;
      r.discard = 1'b0;
    end
    return r;
  endfunction

  // A start flag on the first bit of a byte restarts from the reset state
  assign eff = (bidx == BIT_FIRST && in_word.start_image) ? DEC_RESET : st;
  assign src = rep_on ? st : eff;

  // Position bookkeeping for a sample taken from src
  assign col_inc    = src.col + 1'b1;
  assign wrap       = (col_inc >= cfg.width);
  assign col_after  = wrap ? '0 : col_inc;
  assign row_after  = wrap ? src.row + 1'b1 : src.row;
  assign full_src   = plane_full(cfg, src.row);
  assign full_after = plane_full(cfg, row_after);
  assign x16 = src.row[0] ? (PIX_W'(cfg.width) - PIX_W'(1) - PIX_W'(src.col))
                          : PIX_W'(src.col);

  always_comb begin
    logic       bit_in;
    logic [7:0] pb;
    logic [3:0] pc;
    logic [3:0] need;
    logic [7:0] v;
    logic [7:0] half;
    n             = st;
    bidx_next     = bidx;
    rep_on_next   = rep_on;
    rep_cnt_next  = rep_cnt;
    rep_last_next = rep_last;
    in_pop_req    = 1'b0;
    byte_end      = 1'b0;
    emit_now      = 1'b0;
    emit_val      = st.cur;
    bit_in        = in_word.data_byte[bidx];
    pb            = {eff.pend_bits[6:0], bit_in};
    pc            = eff.pend_count + 4'd1;
    unique case (eff.phase)
      PH_SEED:  need = SEED_BITS;
      PH_CODE:  need = CODE_BITS;
      PH_WBIT:  need = WBIT_BITS;
      default:  need = eff.field_width;
    endcase
    v    = pb & (8'hFF >> (4'd8 - need));
    half = {1'b0, v[7:1]};

    if (rep_on) begin
      // Repeat group: one sample a cycle while not stalled, until four are out or the plane fills
      if (rep_cnt == '0 || full_src) begin
        if (full_src) n = finish_plane(st);
        rep_on_next = 1'b0;
        if (rep_last) byte_end = 1'b1;
      end else begin
        emit_now     = 1'b1;
        emit_val     = st.cur;
        n.col        = col_after;
        n.row        = row_after;
        rep_cnt_next = rep_cnt - 3'd1;
      end
    end else if (!in_empty) begin
      n = eff;
      if (eff.finished) begin
        // Drop the rest of the byte
        in_pop_req = 1'b1;
        byte_end   = 1'b1;
        bidx_next  = BIT_FIRST;
      end else begin
        n.pend_bits  = pb;
        n.pend_count = pc;
        bidx_next    = bidx - 3'd1;
        if (pc >= need) begin
          n.pend_bits  = 8'd0;
          n.pend_count = 4'd0;
          unique case (eff.phase)
            PH_SEED: begin
              if (full_src) begin
                n.finished = 1'b1;
              end else begin
                emit_now = 1'b1;
                emit_val = v;
                n.cur    = v;
                n.col    = col_after;
                n.row    = row_after;
                if (full_after) n = finish_plane(n);
                else n.phase = PH_CODE;
              end
            end
            PH_CODE: begin
              if (v == CODE_REPEAT) begin
                rep_on_next  = 1'b1;
                rep_cnt_next = REP_GROUP;
              end else if (v == CODE_WIDE) begin
                n.phase = PH_WBIT;
              end else begin
                n.field_width = v[3:0] + 4'd2;
                n.slot        = 2'd0;
                n.phase       = PH_FIELD;
              end
            end
            PH_WBIT: begin
              n.field_width = v[3:0] + 4'd1;
              n.slot        = 2'd0;
              n.phase       = PH_FIELD;
            end
            default: begin
              if (eff.discard || full_src) begin
                n = finish_plane(n);
              end else begin
                if (eff.field_width == RAW_WIDTH) emit_val = v;
                else if (v[0]) emit_val = eff.cur + half + 8'd1;
                else emit_val = eff.cur - half;
                emit_now = 1'b1;
                n.cur    = emit_val;
                n.col    = col_after;
                n.row    = row_after;
                if (full_after) begin
                  if (eff.slot != LAST_SLOT) n.discard = 1'b1;
                  else n = finish_plane(n);
                end else if (eff.slot == LAST_SLOT) begin
                  n.slot  = 2'd0;
                  n.phase = PH_CODE;
                end else begin
                  n.slot = eff.slot + 2'd1;
                end
              end
            end
          endcase
        end
        if (bidx == BIT_LAST) begin
          in_pop_req = 1'b1;
          // A repeat group started by the last bit closes the byte when done
          if (rep_on_next) rep_last_next = 1'b1;
          else byte_end = 1'b1;
        end else begin
          rep_last_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    em              = '0;
    em.pixel_x      = x16;
    em.pixel_y      = PIX_W'(src.row);
    em.color_plane  = src.plane;
    em.sample_value = emit_val;
    em.last_of_item = 1'b0;
    em.end_of_image = (src.plane == PLANE_RED) && full_after;
  end

  // The newest sample waits in hold until a later one or the byte end marks it
  assign stall    = hold_valid && (hold_done || emit_now) && out_full;
  assign out_push = hold_valid && (hold_done || emit_now) && !out_full;
  assign in_pop   = in_pop_req && !stall;

  always_comb begin
    out_word              = hold;
    out_word.last_of_item = hold_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= DEC_RESET;
      bidx       <= BIT_FIRST;
      rep_on     <= 1'b0;
      rep_cnt    <= 3'd0;
      rep_last   <= 1'b0;
      hold_valid <= 1'b0;
      hold_done  <= 1'b0;
    end else if (!stall) begin
      st       <= n;
      bidx     <= bidx_next;
      rep_on   <= rep_on_next;
      rep_cnt  <= rep_cnt_next;
      rep_last <= rep_last_next;
      if (emit_now) begin
        hold_valid <= 1'b1;
        hold_done  <= byte_end;
      end else if (hold_valid && hold_done) begin
        hold_valid <= 1'b0;
      end else if (byte_end) begin
        hold_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && emit_now) hold <= em;
  end

endmodule

`default_nettype wire

// ===== design/dbid_outq.sv =====
// Result queue: buffers decoded sample words for the consumer.
// Depends on dbid_pkg for the result type and queue geometry.
`default_nettype none

module dbid_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dbid_pkg::result_t wr_word,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output dbid_pkg::result_t rd_word
);
  import dbid_pkg::*;

  result_t            slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_word;
  end

endmodule

`default_nettype wire

// ===== design/delta_bitstream_image_decoder_core.sv =====
// Delta bitstream image decoder, top level. The bit decoder takes one stream bit per cycle
// while the byte queue has data and a full result queue does not stall it, and pauses its
// bits while a repeat group puts out its samples and a closing check; at most one word a cycle enters the result queue.
// A decoded sample is held until the next sample or the end of its byte marks it, then enters
// the result queue; it waits while that queue is full.
// Reset (synchronous, rst high): queues empty, blue-plane seed awaited, width and height 1.
`default_nettype none

module delta_bitstream_image_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      data_byte,
  input  logic                            start_image,
  output logic                            empty,
  input  logic                            pop,
  output logic [dbid_pkg::PIX_W-1:0]      pixel_x,
  output logic [dbid_pkg::PIX_W-1:0]      pixel_y,
  output logic [1:0]                      color_plane,
  output logic [7:0]                      sample_value,
  output logic                            last_of_item,
  output logic                            end_of_image,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [dbid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dbid_pkg::*;

  cfg_t       cfg;
  byte_word_t in_word, q_word;
  logic       q_empty, q_pop;
  result_t    dec_word, res_word;
  logic       dec_push, res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= DIM_BITS'(1);
      cfg.height <= DIM_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  cfg.width  <= cfg_data[DIM_BITS-1:0];
        CFG_IDX_HEIGHT: cfg.height <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_word.data_byte   = data_byte;
  assign in_word.start_image = start_image;

  dbid_inq u_inq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_word (in_word),
    .full    (full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_word (q_word)
  );

  dbid_dec u_dec (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_empty (q_empty),
    .in_word  (q_word),
    .in_pop   (q_pop),
    .out_full (res_full),
    .out_push (dec_push),
    .out_word (dec_word)
  );

  dbid_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (dec_push),
    .wr_word (dec_word),
    .full    (res_full),
    .pop     (pop),
    .empty   (empty),
    .rd_word (res_word)
  );

  assign pixel_x      = res_word.pixel_x;
  assign pixel_y      = res_word.pixel_y;
  assign color_plane  = res_word.color_plane;
  assign sample_value = res_word.sample_value;
  assign last_of_item = res_word.last_of_item;
  assign end_of_image = res_word.end_of_image;

endmodule

`default_nettype wire

// ===== verif/delta_bitstream_image_decoder_core_tb.sv =====
// Self-checking bench for delta_bitstream_image_decoder_core: streams images through
// the byte queue, predicts every sample from a local decoder and checks the result queue.
// Depends on dbid_pkg for the result layout, decode phases, codes and register indexes.

module delta_bitstream_image_decoder_core_tb;
  import dbid_pkg::*;

  localparam logic [1:0] PLANE_GREEN = 2'd1;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 305;
  localparam int N_DIRECTED = 25;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic [15:0] w;
    logic [15:0] h;
    logic        typed;
    logic        has_sample;
    result_t     sample;
  } dir_row_t;

  localparam result_t NO_SAMPLE = '0;

  // Typed rows run on the power-up geometry of one pixel; the rest go to the predictor.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // no start flag after reset: still a fresh image
    '{8'hFF, 1'b0, 16'd1, 16'd1, 1'b1, 1'b1,
      '{16'd0, 16'd0, PLANE_BLUE, 8'hFF, 1'b1, 1'b0}},
    '{8'h00, 1'b0, 16'd1, 16'd1, 1'b1, 1'b1,
      '{16'd0, 16'd0, PLANE_GREEN, 8'h00, 1'b1, 1'b0}},
    '{8'h80, 1'b0, 16'd1, 16'd1, 1'b1, 1'b1,
      '{16'd0, 16'd0, PLANE_RED, 8'h80, 1'b1, 1'b1}},
    // past the end of the image: dropped until the next start flag
    '{8'h5A, 1'b0, 16'd1, 16'd1, 1'b1, 1'b0, NO_SAMPLE},
    '{8'h01, 1'b1, 16'd1, 16'd1, 1'b1, 1'b1,
      '{16'd0, 16'd0, PLANE_BLUE, 8'h01, 1'b1, 1'b0}},
    '{8'hFE, 1'b0, 16'd1, 16'd1, 1'b1, 1'b1,
      '{16'd0, 16'd0, PLANE_GREEN, 8'hFE, 1'b1, 1'b0}},
    '{8'h7F, 1'b0, 16'd1, 16'd1, 1'b1, 1'b1,
      '{16'd0, 16'd0, PLANE_RED, 8'h7F, 1'b1, 1'b1}},
    // 3x2: repeat group, one-bit and two-bit fields, raw load, and a plane
    // filled mid-group with a dropped field
    '{8'h10, 1'b1, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h1D, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h78, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h7F, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h26, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'hAA, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h55, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h00, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h3F, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h11, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h7F, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h80, 1'b0, 16'd3, 16'd2, 1'b0, 1'b0, NO_SAMPLE},
    // 2x1: repeat group cut short at the plane end
    '{8'h40, 1'b1, 16'd2, 16'd1, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h00, 1'b0, 16'd2, 16'd1, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h00, 1'b0, 16'd2, 16'd1, 1'b0, 1'b0, NO_SAMPLE},
    '{8'hFF, 1'b0, 16'd2, 16'd1, 1'b0, 1'b0, NO_SAMPLE},
    // largest geometry
    '{8'hC3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, NO_SAMPLE},
    '{8'h00, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, NO_SAMPLE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic start_image = 1'b0;
  logic pop = 1'b0;
  logic cfg_write = 1'b0;
  logic cfg_index = CFG_IDX_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic full, empty;
  logic [PIX_W-1:0] pixel_x, pixel_y;
  logic [1:0] color_plane;
  logic [7:0] sample_value;
  logic last_of_item, end_of_image;

  // Local decoder copy
  logic [15:0] geo_w = 16'd1;
  logic [15:0] geo_h = 16'd1;
  logic [7:0] dec_bits;
  int dec_count;
  logic [1:0] dec_phase;
  int dec_width;
  int dec_slot;
  logic [7:0] dec_value;
  logic [1:0] dec_plane;
  logic [15:0] dec_col, dec_row;
  bit dec_discard, dec_done;

  result_t byte_samples[$];
  result_t due_samples[$];
  bit image_bits[$];
  logic [7:0] image_bytes[$];
  int mismatches = 0;
  int live_bytes = 0;
  int push_max_gap = 6;
  int pop_max_gap = 6;
  bit hold_request = 1'b0;

  delta_bitstream_image_decoder_core dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .data_byte(data_byte), .start_image(start_image),
    .empty(empty), .pop(pop),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .color_plane(color_plane),
    .sample_value(sample_value), .last_of_item(last_of_item), .end_of_image(end_of_image),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void restart_decoder();
    dec_bits = 8'd0;
    dec_count = 0;
    dec_phase = PH_SEED;
    dec_width = 0;
    dec_slot = 0;
    dec_value = 8'd0;
    dec_plane = PLANE_BLUE;
    dec_col = 16'd0;
    dec_row = 16'd0;
    dec_discard = 1'b0;
    dec_done = 1'b0;
  endfunction

  function automatic bit plane_filled();
    return geo_w == 16'd0 || geo_h == 16'd0 || dec_row >= geo_h;
  endfunction

  function automatic void close_plane();
    if (dec_plane == PLANE_RED) begin
      dec_done = 1'b1;
      return;
    end
    dec_plane = dec_plane - 2'd1;
    dec_phase = PH_SEED;
    dec_col = 16'd0;
    dec_row = 16'd0;
    dec_slot = 0;
    dec_discard = 1'b0;
  endfunction

  function automatic void emit_sample();
    result_t s;
    // odd rows run right to left; a column past a shrunk width wraps
    s.pixel_x = dec_row[0] ? geo_w - 16'd1 - dec_col : dec_col;
    s.pixel_y = dec_row;
    s.color_plane = dec_plane;
    s.sample_value = dec_value;
    s.last_of_item = 1'b0;
    dec_col = dec_col + 16'd1;
    if (dec_col >= geo_w) begin
      dec_col = 16'd0;
      dec_row = dec_row + 16'd1;
    end
    s.end_of_image = (dec_plane == PLANE_RED) && plane_filled();
    byte_samples.push_back(s);
  endfunction

  function automatic void shift_bit(bit b);
    int need;
    logic [7:0] v;
    dec_bits = {dec_bits[6:0], b};
    dec_count++;
    case (dec_phase)
      PH_SEED: need = SEED_BITS;
      PH_CODE: need = CODE_BITS;
      PH_WBIT: need = WBIT_BITS;
      default: need = dec_width;
    endcase
    if (dec_count < need) return;
    v = dec_bits & ((8'd1 << need) - 1);
    dec_bits = 8'd0;
    dec_count = 0;
    case (dec_phase)
      PH_SEED: begin
        // nothing left to fill: the image is over
        if (plane_filled()) begin
          dec_done = 1'b1;
          return;
        end
        dec_value = v;
        emit_sample();
        if (plane_filled()) close_plane();
        else dec_phase = PH_CODE;
      end
      PH_CODE: begin
        if (v == CODE_REPEAT) begin
          for (int k = 0; k < REP_GROUP; k++) begin
            if (plane_filled()) break;
            emit_sample();
          end
          if (plane_filled()) close_plane();
        end else if (v == CODE_WIDE) begin
          dec_phase = PH_WBIT;
        end else begin
          dec_width = v + 2;
          dec_slot = 0;
          dec_phase = PH_FIELD;
        end
      end
      PH_WBIT: begin
        dec_width = v + 1;
        dec_slot = 0;
        dec_phase = PH_FIELD;
      end
      default: begin
        if (dec_discard || plane_filled()) begin
          close_plane();
          return;
        end
        if (dec_width == RAW_WIDTH) dec_value = v;
        else if (v[0]) dec_value = dec_value + (v >> 1) + 8'd1;
        else dec_value = dec_value - (v >> 1);
        emit_sample();
        if (plane_filled()) begin
          // filled mid-group: one more field is read and dropped
          if (dec_slot < LAST_SLOT) dec_discard = 1'b1;
          else close_plane();
        end else if (dec_slot >= LAST_SLOT) begin
          dec_slot = 0;
          dec_phase = PH_CODE;
        end else begin
          dec_slot++;
        end
      end
    endcase
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic s);
    if (s || !dec_done) live_bytes++;
    if (s) restart_decoder();
    byte_samples.delete();
    for (int i = 7; i >= 0; i--) begin
      if (dec_done) break;
      shift_bit(b[i]);
    end
    if (byte_samples.size() > 0) byte_samples[byte_samples.size() - 1].last_of_item = 1'b1;
  endfunction

  function automatic void put_bits(int unsigned value, int count);
    for (int k = count - 1; k >= 0; k--) image_bits.push_back(value[k]);
  endfunction

  // Encode a well-formed image with random codes and fields, capped in length.
  function automatic void build_image(longint samples, int cap_bytes);
    longint remaining;
    int code, fw;
    logic [7:0] packed_byte;
    image_bits.delete();
    image_bytes.delete();
    for (int p = 0; p < 3; p++) begin
      put_bits($urandom_range(0, 255), SEED_BITS);
      remaining = samples - 1;
      while (remaining > 0 && image_bits.size() < cap_bytes * 8) begin
        code = $urandom_range(0, 7);
        put_bits(code, CODE_BITS);
        if (code == CODE_REPEAT) begin
          remaining -= (remaining > REP_GROUP) ? REP_GROUP : remaining;
        end else begin
          if (code == CODE_WIDE) begin
            fw = $urandom_range(1, 2);
            put_bits(fw - 1, WBIT_BITS);
          end else begin
            fw = code + 2;
          end
          for (int slot = 0; slot < 4; slot++) begin
            put_bits($urandom_range(0, (1 << fw) - 1), fw);
            remaining--;
            if (remaining == 0) begin
              if (slot < LAST_SLOT) put_bits($urandom_range(0, (1 << fw) - 1), fw);
              break;
            end
          end
        end
      end
    end
    while (image_bits.size() % 8 != 0) image_bits.push_back(1'($urandom_range(0, 1)));
    for (int i = 0; i + 8 <= image_bits.size() && i < cap_bytes * 8; i += 8) begin
      for (int k = 0; k < 8; k++) packed_byte[7 - k] = image_bits[i + k];
      image_bytes.push_back(packed_byte);
    end
  endfunction

  task automatic feed_byte(input logic [7:0] b, input logic s, input logic typed,
                           input logic has_sample, input result_t sample);
    int gap;
    gap = $urandom_range(0, push_max_gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    start_image <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_byte(b, s);
    if (typed) begin
      if (has_sample) due_samples.push_back(sample);
    end else begin
      foreach (byte_samples[k]) due_samples.push_back(byte_samples[k]);
    end
  endtask

  // Hold the input until every sample is back, then let any silent bytes drain.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [15:0] w, input logic [15:0] h);
    cfg_write <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
    geo_w = w;
    geo_h = h;
  endtask

  function automatic void log_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t %s: exp x=%0d y=%0d plane=%0d val=%02h last=%0b eoi=%0b",
             $time, what, want.pixel_x, want.pixel_y, want.color_plane, want.sample_value,
             want.last_of_item, want.end_of_image);
      $display(" | got x=%0d y=%0d plane=%0d val=%02h last=%0b eoi=%0b",
               got.pixel_x, got.pixel_y, got.color_plane, got.sample_value,
               got.last_of_item, got.end_of_image);
    end
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && pop && !empty) begin
      got = '{pixel_x, pixel_y, color_plane, sample_value, last_of_item, end_of_image};
      if (due_samples.size() == 0) begin
        log_mismatch("unexpected word", NO_SAMPLE, got);
      end else begin
        want = due_samples.pop_front();
        if (got !== want) log_mismatch("word mismatch", want, got);
      end
    end
  end

  // Result side: random pop gaps, plus one long hold-off on request.
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = $urandom_range(0, pop_max_gap);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    #4000000;
    $display("delta_bitstream_image_decoder_core verification failed");
    $finish;
  end

  initial begin
    dir_row_t row;
    longint samples;
    int cut, shift_at, phase_no, n_img;
    logic [15:0] w, h;
    restart_decoder();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.w != geo_w || row.h != geo_h) begin
        wait_for_drain();
        set_geometry(row.w, row.h);
      end
      feed_byte(row.data, row.start, row.typed, row.has_sample, row.sample);
    end

    live_bytes = 0;
    phase_no = 0;
    while (live_bytes < RANDOM_ITEMS) begin
      wait_for_drain();
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
        h = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
      end else begin
        w = 16'($urandom_range(1, 4));
        h = 16'($urandom_range(1, 3));
      end
      // full-size images while the result side is held off, so both queues fill
      if (phase_no == 2) begin
        w = 16'd4;
        h = 16'd3;
      end
      set_geometry(w, h);
      push_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      pop_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      // stall the result side while bytes keep coming, so both queues back up
      if (phase_no == 2) begin
        push_max_gap = 0;
        hold_request = 1'b1;
      end
      n_img = $urandom_range(1, 3);
      repeat (n_img) begin
        samples = longint'(geo_w) * longint'(geo_h);
        build_image(samples, (samples > 64) ? 10 : 80);
        cut = image_bytes.size();
        if (phase_no != 2 && $urandom_range(0, 4) == 0) cut = $urandom_range(1, cut);
        shift_at = (phase_no != 2 && cut > 1 && $urandom_range(0, 7) == 0)
                   ? $urandom_range(1, cut - 1) : -1;
        for (int j = 0; j < cut; j++) begin
          // geometry change part-way through an image
          if (j == shift_at) begin
            wait_for_drain();
            set_geometry(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)));
          end
          feed_byte(image_bytes[j], j == 0, 1'b0, 1'b0, NO_SAMPLE);
        end
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 4))
            feed_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, 1'b0,
                      NO_SAMPLE);
      end
      phase_no++;
    end

    wait_for_drain();
    if (mismatches == 0) begin
      $display("delta_bitstream_image_decoder_core verification clean");
    end else begin
      $display("delta_bitstream_image_decoder_core verification failed");
    end
    $finish;
  end

endmodule
